// ----- rtl/core/divide_sqrt_coprocessor_regs_assert.svh -----
// assertion macros shared by the rtl
`ifndef DIVIDE_SQRT_COPROCESSOR_REGS_ASSERT_SVH
`define DIVIDE_SQRT_COPROCESSOR_REGS_ASSERT_SVH
// implication checked every cycle outside reset
`define DSC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define DSC_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/dsc_pkg.sv -----
package dsc_pkg;
  localparam logic [5:0] OFF_DIV_CTRL  = 6'h00;
  localparam logic [5:0] OFF_ROOT_CTRL = 6'h30;
  localparam logic [31:0] DIV_FLAG_ZERO = 32'h0000_4000;
  localparam int unsigned STEPS = 64;

  typedef enum logic [1:0] {
    OP_DIV  = 2'd0,
    OP_ROOT = 2'd1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_OUT
  } state_t;

  // start request to the shared unit
  typedef struct packed {
    logic        start;
    op_t         op;
    logic        nneg;
    logic        qneg;
    logic [63:0] a;
    logic [63:0] b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
    logic [63:0] r;
  } unit_rsp_t;
endpackage

// ----- rtl/core/dsc_unit.sv -----
// shared restoring divider / square-root unit, one bit per cycle
module dsc_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_pkg::unit_req_t req,
  output dsc_pkg::unit_rsp_t rsp
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  dsc_pkg::op_t op_r;
  logic        nneg_r, qneg_r;
  logic [63:0] a_r, a_nxt;      // dividend / radicand shifting out
  logic [63:0] b_r;             // divisor
  logic [65:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [65:0] trial;
  logic [65:0] shifted;
  logic        done_r;

  always_comb begin
    if (op_r == dsc_pkg::OP_ROOT) begin
      shifted = {rem_r[63:0], a_r[63:62]};
      trial   = shifted - {q_r, 2'b01};
    end else begin
      shifted = {rem_r[64:0], a_r[63]};
      trial   = shifted - {2'b00, b_r};
    end
    a_nxt   = (op_r == dsc_pkg::OP_ROOT) ? {a_r[61:0], 2'b00} : {a_r[62:0], 1'b0};
    rem_nxt = trial[65] ? shifted : trial;
    q_nxt   = {q_r[62:0], ~trial[65]};
    cnt_nxt = cnt_r - 7'd1;
    busy_nxt = busy_r && (cnt_r != 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= (req.op == dsc_pkg::OP_ROOT) ? 7'd32 : 7'(dsc_pkg::STEPS);
    end else begin
      busy_r <= busy_nxt;
      done_r <= busy_r && (cnt_r == 7'd1);
      if (busy_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      nneg_r <= req.nneg;
      qneg_r <= req.qneg;
      a_r    <= req.a;
      b_r    <= req.b;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  // sign fix on the way out
  always_comb begin
    rsp.done = done_r;
    rsp.q    = qneg_r ? (64'd0 - q_r) : q_r;
    rsp.r    = nneg_r ? (64'd0 - rem_r[63:0]) : rem_r[63:0];
  end

  `include "divide_sqrt_coprocessor_regs_assert.svh"
  `DSC_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_r)
  `DSC_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `DSC_ASSERT_IMP(a_cnt_live, clk, rst_n, busy_r, cnt_r != 7'd0)
endmodule

// ----- rtl/core/divide_sqrt_coprocessor_regs.sv -----
// channel | dir | tdata fields (lsb up)                                    | tuser
// in_     | in  | byte_offset[5:0] access_len[9:6] write_data[41:10] pad   | cmd
// out_    | out | read_data[31:0]                                          | fault
// a divide-control access with a nonzero divisor runs the shared unit for 64 steps, a
// root-control access for 32 steps; anything else only decodes. an access is accepted in
// IDLE, decoded in FIX, run in RUN when it starts the unit, and held in OUT until taken.
// in_tready returns the cycle after the result is taken. reset clears every register word.
// a result waits in the output register while out_tready is low; in_tready is low until
// it is taken.
module divide_sqrt_coprocessor_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // byte_offset[5:0], access_len[9:6], write_data[41:10]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data
  output logic        out_tuser   // fault
);
  dsc_pkg::state_t state_r, state_nxt;
  logic [31:0] dw_r [8];
  logic [31:0] dctl_r, rctl_r;
  logic [31:0] rw_r [3];
  logic        cmd_r;
  logic [5:0]  off_r;
  logic [3:0]  len_r;
  logic [31:0] wd_r;
  logic [31:0] rd_r;
  logic        flt_r;
  dsc_pkg::unit_req_t req;
  dsc_pkg::unit_rsp_t rsp;
  logic [63:0] n, d;
  logic        dzero;
  logic        is_div, is_root;
  logic [31:0] dctl_post;

  assign is_div  = off_r == dsc_pkg::OFF_DIV_CTRL;
  assign is_root = off_r == dsc_pkg::OFF_ROOT_CTRL;

  // divide control after the computation: mode bits and the zero-divisor flag
  assign dctl_post = (dzero ? dsc_pkg::DIV_FLAG_ZERO : 32'd0) | {30'd0, dctl_r[1:0]};

  // operand selection by mode
  always_comb begin
    case (dctl_r[1:0])
      2'd0: begin n = {{32{dw_r[0][31]}}, dw_r[0]}; d = {{32{dw_r[2][31]}}, dw_r[2]}; end
      2'd1: begin n = {dw_r[1], dw_r[0]}; d = {{32{dw_r[2][31]}}, dw_r[2]}; end
      2'd2: begin n = {dw_r[1], dw_r[0]}; d = {dw_r[3], dw_r[2]}; end
      default: begin n = '0; d = '0; end
    endcase
    dzero = d == 64'd0;
  end

  always_comb begin
    req.start = 1'b0;
    req.op    = is_root ? dsc_pkg::OP_ROOT : dsc_pkg::OP_DIV;
    req.nneg  = !is_root && n[63];
    req.qneg  = !is_root && (n[63] != d[63]);
    req.a     = is_root ? {rw_r[2], rw_r[1]} : (n[63] ? 64'd0 - n : n);
    req.b     = d[63] ? 64'd0 - d : d;
    state_nxt = state_r;
    case (state_r)
      dsc_pkg::ST_IDLE: if (in_tvalid) state_nxt = dsc_pkg::ST_FIX;
      dsc_pkg::ST_FIX: begin
        if (is_root || (is_div && !dzero)) begin
          req.start = 1'b1;
          state_nxt = dsc_pkg::ST_RUN;
        end else state_nxt = dsc_pkg::ST_OUT;
      end
      dsc_pkg::ST_RUN: if (rsp.done) state_nxt = dsc_pkg::ST_OUT;
      dsc_pkg::ST_OUT: if (out_tready) state_nxt = dsc_pkg::ST_IDLE;
      default: state_nxt = dsc_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = state_r == dsc_pkg::ST_IDLE;
  assign out_tvalid = state_r == dsc_pkg::ST_OUT;
  assign out_tdata  = rd_r;
  assign out_tuser  = flt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dsc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // the register file and access handling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) dw_r[i] <= '0;
      for (int i = 0; i < 3; i++) rw_r[i] <= '0;
      dctl_r <= '0;
      rctl_r <= '0;
    end else begin
      if (state_r == dsc_pkg::ST_FIX && is_div)
        dctl_r <= cmd_r ? wd_r : dctl_post;
      if (state_r == dsc_pkg::ST_FIX && is_root)
        rctl_r <= cmd_r ? wd_r : {31'd0, rctl_r[0]};
      if (state_r == dsc_pkg::ST_RUN && rsp.done) begin
        if (is_root) rw_r[0] <= rsp.q[31:0];
        else begin
          dw_r[4] <= rsp.q[31:0];
          dw_r[5] <= rsp.q[63:32];
          dw_r[6] <= rsp.r[31:0];
          dw_r[7] <= rsp.r[63:32];
        end
      end
      if (state_r == dsc_pkg::ST_FIX && cmd_r && len_r == 4'd4) begin
        if (off_r[5:4] == 2'b01 || off_r[5:4] == 2'b10)
          dw_r[3'(off_r[4:2] - 3'd4)] <= wd_r;
        else if (off_r[5:4] == 2'b11 && off_r[3:2] != 2'b00)
          rw_r[2'(off_r[3:2] - 2'd1)] <= wd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      off_r <= in_tdata[5:0];
      len_r <= in_tdata[9:6];
      wd_r  <= in_tdata[41:10];
      cmd_r <= in_tuser;
    end
    if (state_r == dsc_pkg::ST_FIX) begin
      if (is_div) begin
        flt_r <= 1'b0;
        rd_r  <= cmd_r ? 32'd0 : dctl_post;
      end else if (is_root) begin
        flt_r <= 1'b0;
        rd_r  <= cmd_r ? 32'd0 : {31'd0, rctl_r[0]};
      end else if (off_r[5:4] == 2'b00 || (off_r[5:4] == 2'b11 && off_r[3:2] == 2'b00)
               || len_r != 4'd4) begin
        flt_r <= 1'b1;
        rd_r  <= '0;
      end else begin
        flt_r <= 1'b0;
        if (cmd_r) rd_r <= '0;
        else if (off_r[5:4] == 2'b11) rd_r <= rw_r[2'(off_r[3:2] - 2'd1)];
        else rd_r <= dw_r[3'(off_r[4:2] - 3'd4)];
      end
    end
  end

  dsc_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  `include "divide_sqrt_coprocessor_regs_assert.svh"
  `DSC_ASSERT_IMP(a_one_side, clk, rst_n, out_tvalid, !in_tready)
  `DSC_ASSERT_IMP(a_start_fix, clk, rst_n, req.start, state_r == dsc_pkg::ST_FIX)
  `DSC_ASSERT_IMP(a_fault_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 32'd0)
endmodule

// ----- dv/dsc_checker.sv -----
`timescale 1ns / 100ps
module dsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
  } access_rsp_t;

  logic [31:0] div_word[8];
  logic [31:0] div_ctrl;
  logic [31:0] root_word[3];
  logic [31:0] root_ctrl;
  access_rsp_t rsp_q[$];

  assign pending = rsp_q.size();

  function automatic logic [63:0] sx(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'h1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res[31:0];
  endfunction

  task automatic run_div();
    logic [63:0] n, d, un, ud, q, r;
    logic nn, dn;
    case (div_ctrl[1:0])
      2'd0: begin n = sx(div_word[0]); d = sx(div_word[2]); end
      2'd1: begin n = {div_word[1], div_word[0]}; d = sx(div_word[2]); end
      2'd2: begin n = {div_word[1], div_word[0]}; d = {div_word[3], div_word[2]}; end
      default: begin n = 0; d = 0; end
    endcase
    div_ctrl = div_ctrl & 32'h3;
    if (d == 0) begin
      div_ctrl = div_ctrl | dsc_pkg::DIV_FLAG_ZERO;
    end else begin
      nn = n[63];
      dn = d[63];
      un = nn ? -n : n;
      ud = dn ? -d : d;
      q = un / ud;
      r = un % ud;
      if (nn != dn) q = -q;
      if (nn) r = -r;
      div_word[4] = q[31:0];
      div_word[5] = q[63:32];
      div_word[6] = r[31:0];
      div_word[7] = r[63:32];
    end
  endtask

  task automatic predict_access(input logic wr, input logic [5:0] off,
                                input logic [3:0] len, input logic [31:0] wd);
    access_rsp_t e;
    int idx;
    e = '0;
    e.fault = 1'b1;
    if (off >= 6'h10 && off < 6'h30) begin
      if (len == 4) begin
        idx = (off - 6'h10) >> 2;
        e.fault = 1'b0;
        if (wr) div_word[idx] = wd;
        else e.read_data = div_word[idx];
      end
    end else if (off >= 6'h34) begin
      if (len == 4) begin
        idx = (off - 6'h34) >> 2;
        e.fault = 1'b0;
        if (wr) root_word[idx] = wd;
        else e.read_data = root_word[idx];
      end
    end else if (off == dsc_pkg::OFF_DIV_CTRL) begin
      run_div();
      e.fault = 1'b0;
      if (wr) div_ctrl = wd;
      else e.read_data = div_ctrl;
    end else if (off == dsc_pkg::OFF_ROOT_CTRL) begin
      root_word[0] = isqrt({root_word[2], root_word[1]});
      root_ctrl = root_ctrl & 32'h1;
      e.fault = 1'b0;
      if (wr) root_ctrl = wd;
      else e.read_data = root_ctrl;
    end
    rsp_q.push_back(e);
  endtask

  always @(posedge clk) begin
    access_rsp_t e;
    if (!rst_n) begin
      foreach (div_word[i]) div_word[i] = '0;
      foreach (root_word[i]) root_word[i] = '0;
      div_ctrl = '0;
      root_ctrl = '0;
      fail_count <= 0;
      rsp_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (rsp_q.size() == 0) begin
          $error("unexpected result data=%h fault=%b", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = rsp_q.pop_front();
          if (out_tdata !== e.read_data) begin
            $error("read_data expected %h actual %h", e.read_data, out_tdata);
            fail_count <= fail_count + 1;
          end
          if (out_tuser !== e.fault) begin
            $error("fault expected %b actual %b", e.fault, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_access(in_tuser, in_tdata[5:0], in_tdata[9:6], in_tdata[41:10]);
    end
  end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // byte_offset[5:0], access_len[9:6], write_data[41:10]
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // read_data
  logic        out_tuser;       // fault
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [5:0] OFF_DIV_NUM_LO  = 6'h10;
  localparam logic [5:0] OFF_DIV_NUM_HI  = 6'h14;
  localparam logic [5:0] OFF_DIV_DEN_LO  = 6'h18;
  localparam logic [5:0] OFF_DIV_DEN_HI  = 6'h1c;
  localparam logic [5:0] OFF_DIV_QUO_LO  = 6'h20;
  localparam logic [5:0] OFF_DIV_QUO_HI  = 6'h24;
  localparam logic [5:0] OFF_ROOT_WORD   = 6'h34;
  localparam logic [5:0] OFF_ROOT_RAD_LO = 6'h38;
  localparam logic [5:0] OFF_ROOT_RAD_HI = 6'h3c;

  always #5 clk = ~clk;

  divide_sqrt_coprocessor_regs i_dut (.*);

  dsc_checker i_chk (.*);

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random stall before each result, with calm stretches
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (w) @(posedge clk);
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      out_tready <= 1'b0;
    end
  end

  // one bus transaction with a random gap in front; tvalid drops only for a gap
  task automatic send_access(input logic wr, input logic [5:0] off,
                             input logic [3:0] len, input logic [31:0] wd);
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (w != 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tdata  <= {6'b0, wd, len, off};
    in_tuser  <= wr;
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic send_word(input logic [5:0] off, input logic [31:0] wd);
    send_access(1'b1, off, 4'd4, wd);
  endtask

  // operand words mostly near the corners, sometimes fully random
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(0, 20));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    logic [3:0] len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 32/32 divide
    send_word(OFF_DIV_NUM_LO, 32'hffff_fff9);
    send_word(OFF_DIV_DEN_LO, 32'd2);
    send_access(1'b1, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'd0);
    send_access(1'b0, dsc_pkg::OFF_DIV_CTRL, 4'd1, 32'd0);
    send_access(1'b0, OFF_DIV_QUO_LO, 4'd4, 32'd0);
    send_access(1'b0, 6'h29, 4'd4, 32'd0);   // unaligned remainder low
    // most negative by minus one in 64/64
    send_word(OFF_DIV_NUM_HI, 32'h8000_0000);
    send_word(OFF_DIV_NUM_LO, 32'h0);
    send_word(OFF_DIV_DEN_LO, 32'hffff_ffff);
    send_word(OFF_DIV_DEN_HI, 32'hffff_ffff);
    send_access(1'b1, dsc_pkg::OFF_DIV_CTRL, 4'd8, 32'd2);
    send_access(1'b0, dsc_pkg::OFF_DIV_CTRL, 4'd2, 32'd0);
    send_access(1'b0, OFF_DIV_QUO_HI, 4'd4, 32'd0);
    // mode 3 behaves as zero divisor, then a real zero divisor
    send_access(1'b1, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'hffff_ffff);
    send_access(1'b0, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'd0);
    send_word(OFF_DIV_DEN_LO, 32'h0);
    send_access(1'b1, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'd1);
    send_access(1'b0, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'd0);
    // root of full radicand, and faults
    send_word(OFF_ROOT_RAD_LO, 32'hffff_ffff);
    send_word(OFF_ROOT_RAD_HI, 32'hffff_ffff);
    send_access(1'b1, dsc_pkg::OFF_ROOT_CTRL, 4'd3, 32'hffff_ffff);
    send_access(1'b0, OFF_ROOT_WORD, 4'd4, 32'd0);
    send_access(1'b0, 6'h07, 4'd4, 32'd0);   // unmapped
    send_access(1'b1, 6'h32, 4'd4, 32'hffff_ffff); // unmapped
    send_access(1'b1, OFF_DIV_NUM_LO, 4'd15, 32'h1234_5678); // wrong size

    // hold off until the block drains
    stop_input();
    @(posedge clk iff pending == 0);

    // random: mostly operand-set, trigger, read-back sequences
    k = 0;
    while (k < 1150) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(OFF_DIV_NUM_LO, pick_word());
          send_word(OFF_DIV_NUM_HI, pick_word());
          send_word(OFF_DIV_DEN_LO, pick_word());
          send_word(OFF_DIV_DEN_HI, pick_word());
          send_access(1'($urandom_range(0, 1)), dsc_pkg::OFF_DIV_CTRL,
                      4'($urandom_range(0, 15)), $urandom);
          send_access(1'b0, dsc_pkg::OFF_DIV_CTRL, 4'd4, 32'd0);
          send_access(1'b0, OFF_DIV_QUO_LO + 6'($urandom_range(0, 15)), 4'd4, 32'd0);
          k += 7;
        end else begin
          send_word(OFF_ROOT_RAD_LO, pick_word());
          send_word(OFF_ROOT_RAD_HI, pick_word());
          send_access(1'($urandom_range(0, 1)), dsc_pkg::OFF_ROOT_CTRL,
                      4'($urandom_range(0, 15)), $urandom);
          send_access(1'b0, OFF_ROOT_WORD + 6'($urandom_range(0, 11)), 4'd4, 32'd0);
          k += 4;
        end
      end else begin
        len = ($urandom_range(0, 1) == 0) ? 4'd4 : 4'($urandom_range(0, 15));
        send_access(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), len, $urandom);
        k += 1;
      end
    end

    stop_input();
    @(posedge clk iff pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dsc_pkg.sv
rtl/core/dsc_unit.sv
rtl/core/divide_sqrt_coprocessor_regs.sv
dv/dsc_checker.sv
dv/tb_top.sv
